// File: sv/c8_pkg.sv
// Shared constants, codes, tables and types of the CHIP-8 instruction core.
package c8_pkg;

	// Sizes of the machine.
	localparam int MEM_BYTES    = 4096;
	localparam int SCREEN_WIDTH = 64;
	localparam int SCREEN_ROWS  = 32;
	localparam int PIXELS       = SCREEN_WIDTH * SCREEN_ROWS;
	localparam int STACK_DEPTH  = 16;
	localparam int FONT_BYTES   = 80;
	localparam int NUM_VREGS    = 16;
	localparam int SPRITE_W     = 8;

	localparam int ADDR_W = $clog2(MEM_BYTES);
	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int COL_W  = $clog2(SCREEN_WIDTH);
	localparam int PIX_W  = $clog2(PIXELS);
	localparam int SP_W   = $clog2(STACK_DEPTH);
	localparam int VR_W   = $clog2(NUM_VREGS);
	localparam int FONT_W = $clog2(FONT_BYTES);

	localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;
	localparam logic [VR_W-1:0]   VF_IDX   = 4'hF;
	localparam logic [VR_W-1:0]   V0_IDX   = 4'h0;

	// Request types.
	localparam logic [1:0] REQ_EXEC  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_PIXEL = 2'd2;
	localparam logic [1:0] REQ_NOP   = 2'd3;

	// Major opcode nibble.
	localparam logic [3:0] OPC_SYS     = 4'h0;
	localparam logic [3:0] OPC_JP      = 4'h1;
	localparam logic [3:0] OPC_CALL    = 4'h2;
	localparam logic [3:0] OPC_SE_IMM  = 4'h3;
	localparam logic [3:0] OPC_SNE_IMM = 4'h4;
	localparam logic [3:0] OPC_SE_REG  = 4'h5;
	localparam logic [3:0] OPC_LD_IMM  = 4'h6;
	localparam logic [3:0] OPC_ADD_IMM = 4'h7;
	localparam logic [3:0] OPC_ALU     = 4'h8;
	localparam logic [3:0] OPC_SNE_REG = 4'h9;
	localparam logic [3:0] OPC_LD_I    = 4'hA;
	localparam logic [3:0] OPC_JP_V0   = 4'hB;
	localparam logic [3:0] OPC_RND     = 4'hC;
	localparam logic [3:0] OPC_DRW     = 4'hD;
	localparam logic [3:0] OPC_KEY     = 4'hE;
	localparam logic [3:0] OPC_MISC    = 4'hF;

	// Full-word system opcodes.
	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	// Low-byte sub-codes.
	localparam logic [7:0] KEY_SKP    = 8'h9E;
	localparam logic [7:0] MISC_LD_DT = 8'h07;
	localparam logic [7:0] MISC_BCD   = 8'h33;

	// Register-to-register ALU sub-codes.
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	// Built-in hex glyphs, five bytes each.
	localparam logic [7:0] FONT [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_MWR,
		ST_PIX,
		ST_PIXD,
		ST_F0,
		ST_F1,
		ST_F2,
		ST_EX,
		ST_FLAG,
		ST_BCD,
		ST_SPRM,
		ST_SPRR,
		ST_SPRA,
		ST_SPRB,
		ST_DONE
	} state_t;

	// Command bundle to the display row memory.
	typedef struct packed {
		logic                    rd_en;
		logic [ROW_W-1:0]        rd_row;
		logic                    wr_en;
		logic [ROW_W-1:0]        wr_row;
		logic [SCREEN_WIDTH-1:0] wr_data;
		logic                    clr;
	} disp_cmd_t;

	// Command bundle to the data register file.
	typedef struct packed {
		logic            rd_en;
		logic [VR_W-1:0] rd_a;
		logic [VR_W-1:0] rd_b;
		logic            wr_en;
		logic [VR_W-1:0] wr_addr;
		logic [7:0]      wr_data;
	} rf_cmd_t;

endpackage

// File: sv/c8_if.sv
// Request and response channel interfaces of the CHIP-8 instruction core.
interface c8_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic [c8_pkg::ADDR_W-1:0] addr;
	logic [7:0]                data;
	logic [15:0]               keys;
	logic [7:0]                random_byte;

	modport source(output valid, req_type, addr, data, keys, random_byte, input ready);
	modport sink(input valid, req_type, addr, data, keys, random_byte, output ready);
endinterface

interface c8_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [c8_pkg::ADDR_W-1:0] pc_now;
	logic [15:0]               opcode_done;
	logic                      draw_now;
	logic                      pixel_value;
	logic                      fault;

	modport source(output valid, pc_now, opcode_done, draw_now, pixel_value, fault,
		input ready);
	modport sink(input valid, pc_now, opcode_done, draw_now, pixel_value, fault,
		output ready);
endinterface

// File: sv/chip8_instruction_core.sv
// Top level of the CHIP-8 instruction core: request sequencer and datapath.
//
// After reset the core loads the font into bytes 0..79 of program memory and
// zeroes the rest; it takes no request until then. Each request is then
// handled alone, its result leaving through an output register once the work
// ends. An instruction passes through two fetch reads of the single-port
// program memory, a register-file read, execute and result, with a further
// step when it writes the VF flag and three memory writes for FX33. DXYN reads
// each sprite row from program memory and does a read-modify-write of the
// display row it lands on, and of the next screen line as well when the row
// spills onto it.
module chip8_instruction_core (
	input  logic       clk,
	input  logic       arst_n,
	c8_req_if.sink     req,
	c8_rsp_if.source   rsp
);
	import c8_pkg::*;

	state_t state_q, state_d;

	// Latched request.
	logic [1:0]        req_type_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        data_q;
	logic [15:0]       keys_q;
	logic [7:0]        rnd_q;

	// Architectural state held in flops.
	logic [ADDR_W-1:0] pc_q;
	logic [ADDR_W-1:0] i_q;
	logic [SP_W-1:0]   sp_q;
	logic [ADDR_W-1:0] stack_q [STACK_DEPTH];

	// Work registers.
	logic [7:0]              hi_q;
	logic [15:0]             op_q;
	logic [3:0]              row_q;
	logic                    flag_q;
	logic [ADDR_W-1:0]       cnt_q;
	logic [3:0]              digit_q [3];
	logic [SCREEN_WIDTH-1:0] mask_a_q;
	logic [SPRITE_W-2:0]     mask_b_q;
	logic [ROW_W-1:0]        row_a_q;
	logic                    draw_q;
	logic                    pix_q;
	logic                    fault_q;

	// Response register.
	logic              rsp_valid_q;
	logic [ADDR_W-1:0] pc_now_q;
	logic [15:0]       opcode_done_q;
	logic              draw_now_q;
	logic              pixel_value_q;
	logic              fault_out_q;

	// Memory ports.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;
	disp_cmd_t               disp_cmd;
	logic [SCREEN_WIDTH-1:0] disp_rd;
	rf_cmd_t    rf_cmd;
	logic [7:0] vx;
	logic [7:0] vy;

	c8_ram #(.DEPTH(MEM_BYTES), .WIDTH(8)) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	c8_display u_disp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (disp_cmd),
		.rd_data (disp_rd)
	);

	c8_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (rf_cmd),
		.rd_a_data (vx),
		.rd_b_data (vy)
	);

	// Instruction fields.
	logic [15:0]       op_fetch;
	logic [VR_W-1:0]   op_x;
	logic [3:0]        op_n;
	logic [7:0]        op_nn;
	logic [ADDR_W-1:0] op_nnn;
	logic [ADDR_W-1:0] pc_next;
	logic [ADDR_W-1:0] pc_skip;
	logic [SP_W-1:0]   sp_inc;
	logic [SP_W-1:0]   sp_dec;
	logic              accept;
	logic              out_go;

	assign op_fetch = {hi_q, ram_rdata};
	assign op_x     = op_q[11:8];
	assign op_n     = op_q[3:0];
	assign op_nn    = op_q[7:0];
	assign op_nnn   = op_q[11:0];
	assign pc_next  = pc_q + ADDR_W'(2);
	assign pc_skip  = pc_q + ADDR_W'(4);
	assign sp_inc   = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + SP_W'(1);
	assign sp_dec   = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - SP_W'(1);
	assign accept   = req.valid && req.ready;
	assign out_go   = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Execute-stage decode.
	logic              ex_known;
	logic [ADDR_W-1:0] ex_pc;
	logic              ex_wx;
	logic [7:0]        ex_wx_data;
	logic              ex_flag_en;
	logic              ex_flag;
	logic              ex_clr;
	logic              ex_push;
	logic              ex_pop;
	logic              ex_set_i;
	logic              ex_draw;
	logic              ex_bcd;
	logic [8:0]        sum9;

	assign sum9 = {1'b0, vx} + {1'b0, vy};

	always_comb begin
		ex_known   = 1'b1;
		ex_pc      = pc_next;
		ex_wx      = 1'b0;
		ex_wx_data = '0;
		ex_flag_en = 1'b0;
		ex_flag    = 1'b0;
		ex_clr     = 1'b0;
		ex_push    = 1'b0;
		ex_pop     = 1'b0;
		ex_set_i   = 1'b0;
		ex_draw    = 1'b0;
		ex_bcd     = 1'b0;
		unique case (op_q[15:12])
			OPC_SYS: begin
				if (op_q == OP_CLS) begin
					ex_clr = 1'b1;
				end else if (op_q == OP_RET) begin
					ex_pop = 1'b1;
					ex_pc  = stack_q[sp_dec] + ADDR_W'(2);
				end else begin
					ex_known = 1'b0;
				end
			end
			OPC_JP: ex_pc = op_nnn;
			OPC_CALL: begin
				ex_push = 1'b1;
				ex_pc   = op_nnn;
			end
			OPC_SE_IMM:  ex_pc = (vx == op_nn) ? pc_skip : pc_next;
			OPC_SNE_IMM: ex_pc = (vx != op_nn) ? pc_skip : pc_next;
			OPC_SE_REG:  ex_pc = (vx == vy) ? pc_skip : pc_next;
			OPC_SNE_REG: ex_pc = (vx != vy) ? pc_skip : pc_next;
			OPC_LD_IMM: begin
				ex_wx      = 1'b1;
				ex_wx_data = op_nn;
			end
			OPC_ADD_IMM: begin
				ex_wx      = 1'b1;
				ex_wx_data = vx + op_nn;
			end
			OPC_ALU: begin
				ex_wx = 1'b1;
				unique case (op_n)
					ALU_MOV: ex_wx_data = vy;
					ALU_OR:  ex_wx_data = vx | vy;
					ALU_AND: ex_wx_data = vx & vy;
					ALU_XOR: ex_wx_data = vx ^ vy;
					ALU_ADD: begin
						ex_wx_data = sum9[7:0];
						ex_flag_en = 1'b1;
						ex_flag    = sum9[8];
					end
					ALU_SUB: begin
						ex_wx_data = vx - vy;
						ex_flag_en = 1'b1;
						ex_flag    = (vx >= vy);
					end
					ALU_SHR: begin
						ex_wx_data = {1'b0, vx[7:1]};
						ex_flag_en = 1'b1;
						ex_flag    = vx[0];
					end
					ALU_SUBN: begin
						ex_wx_data = vy - vx;
						ex_flag_en = 1'b1;
						ex_flag    = (vy >= vx);
					end
					ALU_SHL: begin
						ex_wx_data = {vx[6:0], 1'b0};
						ex_flag_en = 1'b1;
						ex_flag    = vx[7];
					end
					default: begin
						ex_wx    = 1'b0;
						ex_known = 1'b0;
					end
				endcase
			end
			OPC_LD_I:  ex_set_i = 1'b1;
			OPC_JP_V0: ex_pc = {4'b0, vx} + op_nnn;
			OPC_RND: begin
				ex_wx      = 1'b1;
				ex_wx_data = rnd_q & op_nn;
			end
			OPC_DRW: ex_draw = 1'b1;
			OPC_KEY: begin
				if (op_nn == KEY_SKP) begin
					ex_pc = ((vx[7:4] == 4'h0) && keys_q[vx[3:0]]) ? pc_skip : pc_next;
				end else begin
					ex_known = 1'b0;
				end
			end
			OPC_MISC: begin
				if (op_nn == MISC_LD_DT) begin
					ex_wx = 1'b1;
				end else if (op_nn == MISC_BCD) begin
					ex_bcd = 1'b1;
				end else begin
					ex_known = 1'b0;
				end
			end
			default: ex_known = 1'b0;
		endcase
	end

	// Decimal digits of VX: hundreds by compare, tens by reciprocal multiply.
	logic [1:0]  bcd_h;
	logic [7:0]  bcd_rem;
	logic [14:0] bcd_prod;
	logic [3:0]  bcd_t;
	logic [7:0]  bcd_o;

	always_comb begin
		bcd_h    = (vx >= 8'd200) ? 2'd2 : ((vx >= 8'd100) ? 2'd1 : 2'd0);
		bcd_rem  = vx - 8'(bcd_h) * 8'd100;
		bcd_prod = 15'(bcd_rem) * 15'd205;
		bcd_t    = bcd_prod[14:11];
		bcd_o    = bcd_rem - 8'(bcd_t) * 8'd10;
	end

	// Sprite row placement: the eight pixels of a row may wrap onto the next line.
	logic [SPRITE_W-1:0]       spr_rev;
	logic [ROW_W-1:0]          spr_line;
	logic [PIX_W-1:0]          spr_base;
	logic [2*SCREEN_WIDTH-1:0] spr_wide;
	logic                      hit_a;
	logic                      hit_b;
	logic [SCREEN_WIDTH-1:0]   mask_b_ext;

	always_comb begin
		for (int c = 0; c < SPRITE_W; c++) begin
			spr_rev[c] = ram_rdata[SPRITE_W-1-c];
		end
		spr_line = vy[ROW_W-1:0] + ROW_W'(row_q);
		spr_base = PIX_W'(vx) + {spr_line, COL_W'(0)};
		spr_wide = {(2*SCREEN_WIDTH-SPRITE_W)'(0), spr_rev} << spr_base[COL_W-1:0];
	end

	assign mask_b_ext = {(SCREEN_WIDTH-SPRITE_W+1)'(0), mask_b_q};
	assign hit_a      = |(disp_rd & mask_a_q);
	assign hit_b      = |(disp_rd & mask_b_ext);

	// Sequencer: next state and memory commands.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = pc_q;
		ram_wdata = '0;
		disp_cmd  = '0;
		rf_cmd    = '0;
		unique case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_addr  = cnt_q;
				ram_wdata = (cnt_q < ADDR_W'(FONT_BYTES)) ? FONT[cnt_q[FONT_W-1:0]] : '0;
				if (cnt_q == ADDR_W'(MEM_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					unique case (req.req_type)
						REQ_EXEC:  state_d = ST_F0;
						REQ_WRITE: state_d = ST_MWR;
						REQ_PIXEL: state_d = ST_PIX;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_MWR: begin
				ram_we    = 1'b1;
				ram_addr  = addr_q;
				ram_wdata = data_q;
				state_d   = ST_DONE;
			end
			ST_PIX: begin
				disp_cmd.rd_en  = 1'b1;
				disp_cmd.rd_row = addr_q[PIX_W-1:COL_W];
				state_d         = ST_PIXD;
			end
			ST_PIXD: state_d = ST_DONE;
			ST_F0: begin
				ram_addr = pc_q;
				state_d  = ST_F1;
			end
			ST_F1: begin
				ram_addr = pc_q + ADDR_W'(1);
				state_d  = ST_F2;
			end
			ST_F2: begin
				rf_cmd.rd_en = 1'b1;
				rf_cmd.rd_a  = (op_fetch[15:12] == OPC_JP_V0) ? V0_IDX : op_fetch[11:8];
				rf_cmd.rd_b  = op_fetch[7:4];
				state_d      = ST_EX;
			end
			ST_EX: begin
				state_d = ST_DONE;
				if (ex_known) begin
					rf_cmd.wr_en   = ex_wx;
					rf_cmd.wr_addr = op_x;
					rf_cmd.wr_data = ex_wx_data;
					disp_cmd.clr   = ex_clr;
					if (ex_draw) begin
						state_d = (op_n == 4'd0) ? ST_FLAG : ST_SPRM;
					end else if (ex_bcd) begin
						state_d = ST_BCD;
					end else if (ex_flag_en) begin
						state_d = ST_FLAG;
					end
				end
			end
			ST_FLAG: begin
				rf_cmd.wr_en   = 1'b1;
				rf_cmd.wr_addr = VF_IDX;
				rf_cmd.wr_data = {7'b0, flag_q};
				state_d        = ST_DONE;
			end
			ST_BCD: begin
				ram_we    = 1'b1;
				ram_addr  = i_q + cnt_q;
				ram_wdata = {4'b0, digit_q[cnt_q[1:0]]};
				if (cnt_q[1:0] == 2'd2) begin
					state_d = ST_DONE;
				end
			end
			ST_SPRM: begin
				ram_addr = i_q + ADDR_W'(row_q);
				state_d  = ST_SPRR;
			end
			ST_SPRR: begin
				disp_cmd.rd_en  = 1'b1;
				disp_cmd.rd_row = spr_base[PIX_W-1:COL_W];
				state_d         = ST_SPRA;
			end
			ST_SPRA: begin
				disp_cmd.wr_en   = 1'b1;
				disp_cmd.wr_row  = row_a_q;
				disp_cmd.wr_data = disp_rd ^ mask_a_q;
				if (|mask_b_q) begin
					disp_cmd.rd_en  = 1'b1;
					disp_cmd.rd_row = row_a_q + ROW_W'(1);
					state_d         = ST_SPRB;
				end else begin
					state_d = (row_q + 4'd1 == op_n) ? ST_FLAG : ST_SPRM;
				end
			end
			ST_SPRB: begin
				disp_cmd.wr_en   = 1'b1;
				disp_cmd.wr_row  = row_a_q + ROW_W'(1);
				disp_cmd.wr_data = disp_rd ^ mask_b_ext;
				state_d          = (row_q + 4'd1 == op_n) ? ST_FLAG : ST_SPRM;
			end
			ST_DONE: begin
				if (out_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Control and architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_RESET;
			i_q         <= '0;
			sp_q        <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_INIT || state_q == ST_BCD) begin
				cnt_q <= cnt_q + ADDR_W'(1);
			end
			if (state_q == ST_EX && ex_known) begin
				pc_q  <= ex_pc;
				cnt_q <= '0;
				if (ex_set_i) begin
					i_q <= op_nnn;
				end
				if (ex_push) begin
					sp_q <= sp_inc;
				end else if (ex_pop) begin
					sp_q <= sp_dec;
				end
			end
			if (out_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload and work registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			addr_q     <= req.addr;
			data_q     <= req.data;
			keys_q     <= req.keys;
			rnd_q      <= req.random_byte;
			op_q       <= '0;
			draw_q     <= 1'b0;
			pix_q      <= 1'b0;
			fault_q    <= 1'b0;
		end
		unique case (state_q)
			ST_F1: hi_q <= ram_rdata;
			ST_F2: op_q <= op_fetch;
			ST_PIXD: pix_q <= !addr_q[ADDR_W-1] && disp_rd[addr_q[COL_W-1:0]];
			ST_EX: begin
				fault_q    <= !ex_known;
				draw_q     <= ex_known && (ex_draw || ex_clr);
				flag_q     <= ex_flag;
				row_q      <= '0;
				digit_q[0] <= {2'b0, bcd_h};
				digit_q[1] <= bcd_t;
				digit_q[2] <= bcd_o[3:0];
				if (ex_known && ex_push) begin
					stack_q[sp_q] <= pc_q;
				end
			end
			ST_SPRR: begin
				mask_a_q <= spr_wide[SCREEN_WIDTH-1:0];
				mask_b_q <= spr_wide[SCREEN_WIDTH+SPRITE_W-2:SCREEN_WIDTH];
				row_a_q  <= spr_base[PIX_W-1:COL_W];
			end
			ST_SPRA: begin
				flag_q <= flag_q | hit_a;
				if (!(|mask_b_q)) begin
					row_q <= row_q + 4'd1;
				end
			end
			ST_SPRB: begin
				flag_q <= flag_q | hit_b;
				row_q  <= row_q + 4'd1;
			end
			default: begin
			end
		endcase
		if (out_go) begin
			pc_now_q      <= pc_q;
			opcode_done_q <= (req_type_q == REQ_EXEC) ? op_q : '0;
			draw_now_q    <= draw_q;
			pixel_value_q <= pix_q;
			fault_out_q   <= fault_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.pc_now      = pc_now_q;
	assign rsp.opcode_done = opcode_done_q;
	assign rsp.draw_now    = draw_now_q;
	assign rsp.pixel_value = pixel_value_q;
	assign rsp.fault       = fault_out_q;
endmodule

// File: sv/c8_ram.sv
// Single-port synchronous RAM with registered read data.
module c8_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One access per cycle: a write, or a registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

// File: sv/c8_display.sv
// Display frame buffer: one memory row per screen line, with per-row valid bits.
module c8_display (
	input  logic                              clk,
	input  logic                              arst_n,
	input  c8_pkg::disp_cmd_t                 cmd,
	output logic [c8_pkg::SCREEN_WIDTH-1:0]   rd_data
);
	import c8_pkg::*;

	logic [SCREEN_WIDTH-1:0] mem [SCREEN_ROWS];
	logic [SCREEN_ROWS-1:0]  valid_q;
	logic [SCREEN_WIDTH-1:0] rd_q;
	logic                    rd_valid_q;

	// Row valid bits; a clear empties the whole screen at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				valid_q <= '0;
			end else if (cmd.wr_en) begin
				valid_q[cmd.wr_row] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_valid_q <= valid_q[cmd.rd_row];
			end
		end
	end

	// Row storage with one write and one read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_row] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_row];
		end
	end

	// A row never written since the last clear reads as blank.
	assign rd_data = rd_q & {SCREEN_WIDTH{rd_valid_q}};
endmodule

// File: sv/c8_regs.sv
// Data register file V0..VF: two registered read ports, one write port.
module c8_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  c8_pkg::rf_cmd_t cmd,
	output logic [7:0]      rd_a_data,
	output logic [7:0]      rd_b_data
);
	import c8_pkg::*;

	logic [7:0]           mem [NUM_VREGS];
	logic [NUM_VREGS-1:0] valid_q;
	logic [7:0]           rd_a_q;
	logic [7:0]           rd_b_q;
	logic                 va_q;
	logic                 vb_q;

	// Valid bits stand in for the reset value of zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				valid_q[cmd.wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				va_q <= valid_q[cmd.rd_a];
				vb_q <= valid_q[cmd.rd_b];
			end
		end
	end

	// Storage; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_a_q <= mem[cmd.rd_a];
			rd_b_q <= mem[cmd.rd_b];
		end
	end

	assign rd_a_data = rd_a_q & {8{va_q}};
	assign rd_b_data = rd_b_q & {8{vb_q}};
endmodule

// File: sv/c8_checker.sv
// Port-level assertions for the CHIP-8 instruction core, bound to the top level.
module c8_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [c8_pkg::ADDR_W-1:0] pc_now,
	input logic [15:0]               opcode_done,
	input logic                      draw_now,
	input logic                      pixel_value,
	input logic                      fault
);
	import c8_pkg::*;

	// A stalled response beat keeps its valid and its program counter.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(pc_now))
		else $error("response beat dropped or changed while stalled");

	// The core works on one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// Only a screen clear or a sprite draw reports drawing, and never with a fault.
	a_draw_op: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && draw_now |->
			!fault && (opcode_done == OP_CLS || opcode_done[15:12] == OPC_DRW))
		else $error("draw flag on a non-drawing instruction");

	// A pixel value comes only from a read request, which executes nothing.
	a_pixel_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && pixel_value |-> opcode_done == 16'h0000 && !fault && !draw_now)
		else $error("pixel value on an executing request");
endmodule

bind chip8_instruction_core c8_checker u_c8_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.pc_now      (rsp.pc_now),
	.opcode_done (rsp.opcode_done),
	.draw_now    (rsp.draw_now),
	.pixel_value (rsp.pixel_value),
	.fault       (rsp.fault)
);

// File: dv/chip8_checker.sv
// Response checker for the CHIP-8 instruction core: predicts each result and compares it.
module chip8_checker (
	input  logic clk,
	input  logic arst_n,
	c8_req_if    req,
	c8_rsp_if    rsp,
	output int   errors,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import c8_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] pc;
		logic [15:0]       op;
		logic              draw;
		logic              pix;
		logic              fault;
	} step_result_t;

	// Shadow copy of the machine state.
	logic [7:0]        mem [MEM_BYTES];
	logic              screen [PIXELS];
	logic [7:0]        vreg [NUM_VREGS];
	logic [ADDR_W-1:0] ret_stack [STACK_DEPTH];
	logic [SP_W-1:0]   sp;
	logic [ADDR_W-1:0] pc;
	logic [ADDR_W-1:0] ireg;

	step_result_t expected_q [$];

	initial errors = 0;

	task automatic clear_machine();
		for (int i = 0; i < MEM_BYTES; i++) mem[i] = (i < FONT_BYTES) ? FONT[i] : 8'h00;
		for (int i = 0; i < PIXELS; i++) screen[i] = 1'b0;
		for (int i = 0; i < NUM_VREGS; i++) vreg[i] = 8'h00;
		for (int i = 0; i < STACK_DEPTH; i++) ret_stack[i] = '0;
		sp = '0;
		pc = PC_RESET;
		ireg = '0;
	endtask

	// Execute one instruction on the shadow state; sets fault for unknown opcodes.
	task automatic run_instruction(input logic [15:0] op, input logic [15:0] keys,
		input logic [7:0] rnd, output logic draw, output logic fault);
		logic [3:0]        x;
		logic [3:0]        y;
		logic [7:0]        nn;
		logic [7:0]        vx;
		logic [7:0]        vy;
		logic [8:0]        sum;
		logic [ADDR_W-1:0] nnn;
		logic [ADDR_W-1:0] npc;
		logic [ADDR_W-1:0] skip;
		logic              flag;
		logic [PIX_W-1:0]  idx;
		x = op[11:8];
		y = op[7:4];
		nn = op[7:0];
		nnn = op[11:0];
		vx = vreg[x];
		vy = vreg[y];
		npc = pc + 12'd2;
		skip = pc + 12'd4;
		draw = 1'b0;
		fault = 1'b0;
		case (op[15:12])
			OPC_SYS: begin
				if (op == OP_CLS) begin
					for (int i = 0; i < PIXELS; i++) screen[i] = 1'b0;
					draw = 1'b1;
				end else if (op == OP_RET) begin
					sp = (sp == '0) ? SP_W'(STACK_DEPTH - 1) : sp - SP_W'(1);
					npc = ret_stack[sp] + 12'd2;
				end else begin
					fault = 1'b1;
				end
			end
			OPC_JP: npc = nnn;
			OPC_CALL: begin
				ret_stack[sp] = pc;
				sp = (sp == SP_W'(STACK_DEPTH - 1)) ? '0 : sp + SP_W'(1);
				npc = nnn;
			end
			OPC_SE_IMM:  if (vx == nn) npc = skip;
			OPC_SNE_IMM: if (vx != nn) npc = skip;
			OPC_SE_REG:  if (vx == vy) npc = skip;
			OPC_LD_IMM:  vreg[x] = nn;
			OPC_ADD_IMM: vreg[x] = vx + nn;
			OPC_ALU: begin
				case (op[3:0])
					ALU_MOV: vreg[x] = vy;
					ALU_OR:  vreg[x] = vx | vy;
					ALU_AND: vreg[x] = vx & vy;
					ALU_XOR: vreg[x] = vx ^ vy;
					ALU_ADD: begin
						sum = {1'b0, vx} + {1'b0, vy};
						vreg[x] = sum[7:0];
						vreg[VF_IDX] = {7'd0, sum[8]};
					end
					ALU_SUB: begin
						vreg[x] = vx - vy;
						vreg[VF_IDX] = {7'd0, vx >= vy};
					end
					ALU_SHR: begin
						vreg[x] = vx >> 1;
						vreg[VF_IDX] = {7'd0, vx[0]};
					end
					ALU_SUBN: begin
						vreg[x] = vy - vx;
						vreg[VF_IDX] = {7'd0, vy >= vx};
					end
					ALU_SHL: begin
						vreg[x] = vx << 1;
						vreg[VF_IDX] = {7'd0, vx[7]};
					end
					default: fault = 1'b1;
				endcase
			end
			OPC_SNE_REG: if (vx != vy) npc = skip;
			OPC_LD_I:    ireg = nnn;
			OPC_JP_V0:   npc = {4'd0, vreg[V0_IDX]} + nnn;
			OPC_RND:     vreg[x] = rnd & nn;
			OPC_DRW: begin
				// Sprite rows XOR onto the screen; positions wrap over the whole frame.
				flag = 1'b0;
				for (int r = 0; r < op[3:0]; r++) begin
					for (int c = 0; c < SPRITE_W; c++) begin
						if (mem[ADDR_W'(ireg + r)][7-c]) begin
							idx = PIX_W'(int'(vx) + c + (int'(vy) + r) * SCREEN_WIDTH);
							if (screen[idx]) flag = 1'b1;
							screen[idx] = ~screen[idx];
						end
					end
				end
				vreg[VF_IDX] = {7'd0, flag};
				draw = 1'b1;
			end
			OPC_KEY: begin
				if (nn != KEY_SKP) fault = 1'b1;
				else if (vx[7:4] == 4'h0 && keys[vx[3:0]]) npc = skip;
			end
			default: begin
				if (nn == MISC_LD_DT) begin
					vreg[x] = 8'h00;
				end else if (nn == MISC_BCD) begin
					mem[ireg] = vx / 8'd100;
					mem[ireg + 12'd1] = (vx / 8'd10) % 8'd10;
					mem[ireg + 12'd2] = vx % 8'd10;
				end else begin
					fault = 1'b1;
				end
			end
		endcase
		if (!fault) pc = npc;
	endtask

	task automatic check_field(input string what, input logic [15:0] want,
		input logic [15:0] saw);
		if (saw !== want) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, what, want, saw);
		end
	endtask

	// Predict on every request beat, compare on every response beat.
	always @(posedge clk or negedge arst_n) begin
		step_result_t res;
		step_result_t want;
		if (!arst_n) begin
			clear_machine();
			expected_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected response pc %0h op %0h", $time, rsp.pc_now,
						rsp.opcode_done);
				end else begin
					want = expected_q.pop_front();
					check_field("pc_now", 16'(want.pc), 16'(rsp.pc_now));
					check_field("opcode_done", want.op, rsp.opcode_done);
					check_field("draw_now", 16'(want.draw), 16'(rsp.draw_now));
					check_field("pixel_value", 16'(want.pix), 16'(rsp.pixel_value));
					check_field("fault", 16'(want.fault), 16'(rsp.fault));
				end
			end
			if (req.valid && req.ready) begin
				res = '0;
				case (req.req_type)
					REQ_EXEC: begin
						res.op = {mem[pc], mem[pc + 12'd1]};
						run_instruction(res.op, req.keys, req.random_byte, res.draw, res.fault);
					end
					REQ_WRITE: mem[req.addr] = req.data;
					REQ_PIXEL: res.pix = (req.addr < ADDR_W'(PIXELS)) ?
						screen[req.addr[PIX_W-1:0]] : 1'b0;
					default: ;
				endcase
				res.pc = pc;
				expected_q.push_back(res);
			end
		end
		outstanding = expected_q.size();
	end
endmodule

// File: dv/testbench.sv
// Top of the CHIP-8 instruction core testbench: clock, reset, stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import c8_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	c8_req_if req_ch ();
	c8_rsp_if rsp_ch ();

	chip8_instruction_core dut (.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch));

	int errors;
	int outstanding;

	chip8_checker u_checker (.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.errors(errors), .outstanding(outstanding));

	always #5 clk = ~clk;

	// Stimulus bookkeeping: beats sent and answered, program counter seen last.
	int                beats_sent;
	int                beats_back;
	logic [ADDR_W-1:0] last_pc;
	logic [ADDR_W-1:0] prog_pc;
	bit                calm;
	int                hold;

	// Return-stack shadow so that a return never pops an unwritten entry.
	logic [SP_W-1:0]   call_sp;
	bit                frame_set [STACK_DEPTH];

	// Response side: random stall after each beat, none while calm.
	always @(posedge clk or negedge arst_n) begin
		int n;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold <= 0;
			beats_back <= 0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			n = calm ? 0 : $urandom_range(0, 3);
			beats_back <= beats_back + 1;
			last_pc <= rsp_ch.pc_now;
			hold <= n;
			rsp_ch.ready <= (n == 0);
		end else if (hold > 0) begin
			hold <= hold - 1;
			rsp_ch.ready <= (hold == 1);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic send_beat(input logic [1:0] kind, input logic [ADDR_W-1:0] a,
		input logic [7:0] d, input logic [15:0] keys, input logic [7:0] rnd);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.addr <= a;
		req_ch.data <= d;
		req_ch.keys <= keys;
		req_ch.random_byte <= rnd;
		do @(posedge clk); while (!req_ch.ready);
		beats_sent++;
	endtask

	// Stop offering beats and wait until every one sent has been answered.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (beats_back != beats_sent) @(posedge clk);
	endtask

	function automatic bit return_allowed();
		return frame_set[(call_sp == '0) ? SP_W'(STACK_DEPTH - 1) : call_sp - SP_W'(1)];
	endfunction

	// Place an instruction at the program counter, execute it, and learn the new pc.
	task automatic run_op(input logic [15:0] op, input logic [15:0] keys,
		input logic [7:0] rnd);
		send_beat(REQ_WRITE, prog_pc, op[15:8], 16'($urandom), 8'($urandom));
		send_beat(REQ_WRITE, prog_pc + 12'd1, op[7:0], 16'($urandom), 8'($urandom));
		send_beat(REQ_EXEC, 12'($urandom), 8'($urandom), keys, rnd);
		if (op[15:12] == OPC_CALL) begin
			frame_set[call_sp] = 1'b1;
			call_sp = (call_sp == SP_W'(STACK_DEPTH - 1)) ? '0 : call_sp + SP_W'(1);
		end else if (op == OP_RET) begin
			call_sp = (call_sp == '0) ? SP_W'(STACK_DEPTH - 1) : call_sp - SP_W'(1);
		end
		drain();
		prog_pc = last_pc;
	endtask

	function automatic logic [15:0] pick_op();
		logic [15:0] op;
		logic [3:0]  sub [10];
		op = 16'($urandom);
		sub = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN,
			ALU_SHL, 4'h9};
		case (op[15:12])
			OPC_SYS: begin
				case ($urandom_range(0, 3))
					0: op = OP_CLS;
					1: op = return_allowed() ? OP_RET : OP_CLS;
					2: op = return_allowed() ? OP_RET : ((op == OP_RET) ? OP_CLS : op);
					default: if (op == OP_RET) op = OP_CLS;
				endcase
			end
			OPC_ALU: begin
				op[3:0] = sub[$urandom_range(0, 9)];
				if (op[3:0] == 4'h9) op[3:0] = 4'($urandom);
			end
			OPC_KEY: if ($urandom_range(0, 5) != 0) op[7:0] = KEY_SKP;
			OPC_MISC: begin
				case ($urandom_range(0, 4))
					0, 1: op[7:0] = MISC_LD_DT;
					2, 3: op[7:0] = MISC_BCD;
					default: ;
				endcase
			end
			OPC_LD_IMM: if ($urandom_range(0, 1)) op[7:0] = 8'($urandom_range(0, 20));
			default: ;
		endcase
		return op;
	endfunction

	// Run-time limit.
	initial begin
		#20ms;
		$display("chip8_instruction_core: mismatch");
		$finish;
	end

	initial begin
		logic [15:0] directed [] = '{
			16'h6AFF, 16'h6B01, 16'h8AB4, 16'h8AB5, 16'h8AB7, 16'h6AF3, 16'h8AB6,
			16'h8ABE, 16'h8AB1, 16'h8AB2, 16'h8AB3, 16'h8AB0, 16'h3A01, 16'h4A01,
			16'h5AB0, 16'h9AB1, 16'hA000, 16'hD005, 16'hD005, 16'hD000, 16'hD3F5,
			16'h00E0, 16'hC1A5, 16'h6C1F, 16'hEC9E, 16'h6C05, 16'hEC9E, 16'hFC07,
			16'h61FF, 16'hAFFE, 16'hF133, 16'h2300, 16'h00EE, 16'h0123, 16'h8008,
			16'hE0A1, 16'hF0FF, 16'h6080, 16'hBF90, 16'h1FFE, 16'h1200
		};
		int kind;
		beats_sent = 0;
		calm = 1'b0;
		call_sp = '0;
		for (int i = 0; i < STACK_DEPTH; i++) frame_set[i] = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_EXEC;
		req_ch.addr <= '0;
		req_ch.data <= '0;
		req_ch.keys <= '0;
		req_ch.random_byte <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		prog_pc = PC_RESET;

		// Directed: every instruction class but 7XNN, flags, wraps, faults and odd requests.
		foreach (directed[i]) run_op(directed[i], 16'h0020, 8'hFF);
		send_beat(REQ_PIXEL, 12'd0, 8'h00, 16'hFFFF, 8'h00);
		send_beat(REQ_PIXEL, 12'd2047, 8'h00, 16'hFFFF, 8'h00);
		send_beat(REQ_PIXEL, 12'hFFF, 8'h00, 16'hFFFF, 8'h00);
		send_beat(REQ_NOP, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
		send_beat(REQ_WRITE, 12'hFFF, 8'hFF, 16'h0000, 8'h00);

		// Random: mostly placed-and-executed instructions, with reads and noise beats.
		while (beats_sent < 700) begin
			if ($urandom_range(0, 40) == 0) calm = ~calm;
			kind = $urandom_range(0, 19);
			if (kind < 13) begin
				run_op(pick_op(), 16'($urandom), 8'($urandom));
			end else if (kind < 17) begin
				send_beat(REQ_PIXEL,
					($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 2047)),
					8'($urandom), 16'($urandom), 8'($urandom));
			end else if (kind < 19) begin
				send_beat(REQ_WRITE, 12'($urandom), 8'($urandom), 16'($urandom),
					8'($urandom));
			end else begin
				send_beat(REQ_NOP, 12'($urandom), 8'($urandom), 16'($urandom),
					8'($urandom));
			end
		end
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("chip8_instruction_core: match");
		end else begin
			$display("chip8_instruction_core: mismatch");
		end
		$finish;
	end
endmodule

// File: chip8_instruction_core.f
sv/c8_pkg.sv
sv/c8_if.sv
sv/c8_ram.sv
sv/c8_display.sv
sv/c8_regs.sv
sv/chip8_instruction_core.sv
sv/c8_checker.sv
dv/chip8_checker.sv
dv/testbench.sv
